// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the sextet lookup for the Base64 stream decoder.
package b64d_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [7:0] NulChar = 8'h00;

  typedef struct packed {
    logic        is_data;
    logic        error;
    logic        eom;
    logic [1:0]  count;
    logic [23:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
// Front end: accepts characters, tracks group state and issues decode commands.
module b64d_front import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_code_i,
  input  logic       eom_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] held_q, held_d;
  logic        third_pad_q, third_pad_d;
  logic        halted_q, halted_d;

  sextet_t     sx;
  logic        is_pad;
  logic [5:0]  v;
  logic [5:0]  s1, s2, s3;

  always_comb begin
    sx     = sextet_of(char_code_i);
    is_pad = (char_code_i == PadChar);
    v      = sx.ok ? sx.value : 6'd0;
    s1     = held_q[17:12];
    s2     = held_q[11:6];
    s3     = held_q[5:0];

    pos_d       = pos_q;
    held_d      = held_q;
    third_pad_d = third_pad_q;
    halted_d    = halted_q;
    push_o      = 1'b0;
    cmd_o       = '0;
    cmd_o.count = 2'd1;
    cmd_o.eom   = eom_i;

    if (accept_i) begin
      if (halted_q) begin
        if (eom_i) begin
          halted_d = 1'b0;
        end
      end else if (pos_q == 2'd0 && char_code_i == NulChar) begin
        push_o      = 1'b1;
        pos_d       = 2'd0;
        held_d      = '0;
        third_pad_d = 1'b0;
        halted_d    = !eom_i;
      end else if (!sx.ok && !(is_pad && pos_q >= 2'd2)) begin
        push_o      = 1'b1;
        cmd_o.error = 1'b1;
        pos_d       = 2'd0;
        held_d      = '0;
        third_pad_d = 1'b0;
        halted_d    = !eom_i;
      end else if (pos_q != 2'd3) begin
        if (eom_i) begin
          push_o      = 1'b1;
          cmd_o.error = 1'b1;
          pos_d       = 2'd0;
          held_d      = '0;
          third_pad_d = 1'b0;
        end else begin
          unique case (pos_q)
            2'd0:    held_d[17:12] = v;
            2'd1:    held_d[11:6]  = v;
            default: held_d[5:0]   = v;
          endcase
          if (pos_q == 2'd2 && is_pad) begin
            third_pad_d = 1'b1;
          end
          pos_d = pos_q + 2'd1;
        end
      end else begin
        push_o        = 1'b1;
        cmd_o.is_data = 1'b1;
        cmd_o.bytes   = {s3[1:0], v, s2[3:0], s3[5:2], s1, s2[5:4]};
        cmd_o.count   = third_pad_q ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
        pos_d         = 2'd0;
        held_d        = '0;
        third_pad_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      held_q      <= '0;
      third_pad_q <= 1'b0;
      halted_q    <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      held_q      <= held_d;
      third_pad_q <= third_pad_d;
      halted_q    <= halted_d;
    end
  end

endmodule

// ===== hw/rtl/b64d_fifo.sv =====
// Command queue between the front end and the output sequencer.
module b64d_fifo import b64d_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// Back end: expands queued commands into result transfers through an output register.
module b64d_back import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       last_o,
  output logic       error_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       bvalid_q, bvalid_d;
  logic       last_q, last_d;
  logic       err_q, err_d;
  logic       load;
  logic       final_res;

  always_comb begin
    load      = cmd_valid_i && (!valid_q || m_ready_i);
    final_res = (idx_q == cmd_i.count - 2'd1);
    pop_o     = load && final_res;

    idx_d    = idx_q;
    valid_d  = valid_q && !m_ready_i;
    byte_d   = byte_q;
    bvalid_d = bvalid_q;
    last_d   = last_q;
    err_d    = err_q;

    if (load) begin
      valid_d = 1'b1;
      idx_d   = final_res ? 2'd0 : idx_q + 2'd1;
      if (cmd_i.is_data) begin
        unique case (idx_q)
          2'd0:    byte_d = cmd_i.bytes[7:0];
          2'd1:    byte_d = cmd_i.bytes[15:8];
          default: byte_d = cmd_i.bytes[23:16];
        endcase
        bvalid_d = 1'b1;
        last_d   = cmd_i.eom && final_res;
        err_d    = 1'b0;
      end else begin
        byte_d   = 8'd0;
        bvalid_d = 1'b0;
        last_d   = 1'b1;
        err_d    = cmd_i.error;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    bvalid_q <= bvalid_d;
    last_q   <= last_d;
    err_q    <= err_d;
  end

  assign m_valid_o    = valid_q;
  assign data_byte_o  = byte_q;
  assign byte_valid_o = bvalid_q;
  assign last_o       = last_q;
  assign error_o      = err_q;

endmodule

// ===== hw/rtl/base64_stream_decoder_top.sv =====
// Top level of the Base64 stream decoder.
// Usage:
//   Slave channel takes one character per transfer: tdata is the character
//   byte, tlast marks the final character of the message.
//   Master channel gives one result per transfer: tdata is the decoded byte,
//   tuser[0] says the byte is valid, tuser[1] flags an error, tlast marks
//   the final result of the message.
// Path: the character that completes a result is queued as a command; the
//   result then loads into the output register, from which it transfers.
// Throughput: one character per cycle while the queue is not full; the output
//   sequencer gives one result per cycle while the receiver is ready, and a
//   group of four characters gives at most three results. A command queue of
//   Depth entries sits between the two.
// Reset: clears group state, the queue and the output register's valid flag.
// Stall: when the receiver drops tready the output holds; the queue fills
//   and s_axis_tready_o falls only when it is full.
module base64_stream_decoder_top import b64d_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // char_code[7:0]
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // data_byte[7:0]
  output logic [1:0] m_axis_tuser_o,   // byte_valid[0], error[1]
  output logic       m_axis_tlast_o
);

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_out;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (s_axis_tdata_i),
    .eom_i       (s_axis_tlast_i),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  b64d_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .data_byte_o  (m_axis_tdata_o),
    .byte_valid_o (m_axis_tuser_o[0]),
    .last_o       (m_axis_tlast_o),
    .error_o      (m_axis_tuser_o[1])
  );

endmodule

// ===== hw/rtl/b64d_checker.sv =====
// Port-level assertions for the Base64 stream decoder and their bind.
module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  a_err_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("error result carries a byte");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tlast_o)
    else $error("error result without last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tlast_o && m_axis_tdata_o == 8'd0))
    else $error("result without byte is not a zero final result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);
